[hdl/obb_pkg.sv]
// ----------------------------------------------------------------------------
// obb_pkg
// Types, widths and pair tables for the 2D oriented box overlap test.
// ----------------------------------------------------------------------------
package obb_pkg;

    // Input coordinates are signed Q15.8
    localparam int COORD_W  = 24;
    // Center difference is signed Q16.8
    localparam int DIFF_W   = COORD_W + 1;
    // Full-width product of two difference-width operands
    localparam int PROD_W   = 2 * DIFF_W;
    // Sum of two products
    localparam int DOT_W    = PROD_W + 1;
    // Magnitude of a dot product
    localparam int MAG_W    = DOT_W - 1;
    // Span sums and doubled distance
    localparam int SUM_W    = MAG_W + 2;

    localparam int NUM_EDGE = 4;
    // Unique edge-by-edge dot products (symmetric matrix, upper triangle)
    localparam int NUM_PAIR = 10;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic        [MAG_W-1:0]   mag_t;
    typedef logic        [SUM_W-1:0]   sum_t;
    typedef logic        [1:0]         edge_idx_t;
    typedef logic        [3:0]         pair_idx_t;

    // Edge order: left u, left v, right u, right v
    localparam edge_idx_t PAIR_A [NUM_PAIR] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3
    };
    localparam edge_idx_t PAIR_B [NUM_PAIR] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3
    };

    // Pair slot holding dot(edge i, edge k)
    localparam pair_idx_t PAIR_IDX [NUM_EDGE][NUM_EDGE] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3},
        '{4'd1, 4'd4, 4'd5, 4'd6},
        '{4'd2, 4'd5, 4'd7, 4'd8},
        '{4'd3, 4'd6, 4'd8, 4'd9}
    };

endpackage

[hdl/obb_overlap_test_2d.sv]
// ----------------------------------------------------------------------------
// obb_overlap_test_2d
// Separating axis overlap test of two oriented rectangles, fully pipelined.
// Throughput: one box pair per cycle while out_stall is low; seven register
// stages, one set of 28 multipliers per pass, each stage holds its item when
// the next is full.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module obb_overlap_test_2d (
    input  logic           clk,
    input  logic           rst_n,

    input  logic           in_valid,
    output logic           in_stall,
    input  obb_pkg::coord_t left_center_x,
    input  obb_pkg::coord_t left_center_y,
    input  obb_pkg::coord_t left_edge_u_x,
    input  obb_pkg::coord_t left_edge_u_y,
    input  obb_pkg::coord_t left_edge_v_x,
    input  obb_pkg::coord_t left_edge_v_y,
    input  obb_pkg::coord_t right_center_x,
    input  obb_pkg::coord_t right_center_y,
    input  obb_pkg::coord_t right_edge_u_x,
    input  obb_pkg::coord_t right_edge_u_y,
    input  obb_pkg::coord_t right_edge_v_x,
    input  obb_pkg::coord_t right_edge_v_y,

    output logic           out_valid,
    input  logic           out_stall,
    output logic           overlap
);

    import obb_pkg::*;

    localparam int NUM_STAGE = 7;
    localparam int LAST      = NUM_STAGE - 1;

    // Pipeline control
    logic [NUM_STAGE-1:0] stage_valid_reg;
    logic [NUM_STAGE-1:0] stage_valid_next;
    logic [NUM_STAGE-1:0] stage_ready;
    logic [NUM_STAGE-1:0] stage_load;

    // Stage 0: center difference and edges
    diff_t  dx_reg, dy_reg;
    coord_t ex_reg [NUM_EDGE];
    coord_t ey_reg [NUM_EDGE];

    // Stage 1: products
    prod_t pprod_x_next [NUM_PAIR];
    prod_t pprod_y_next [NUM_PAIR];
    prod_t dprod_x_next [NUM_EDGE];
    prod_t dprod_y_next [NUM_EDGE];
    prod_t pprod_x_reg  [NUM_PAIR];
    prod_t pprod_y_reg  [NUM_PAIR];
    prod_t dprod_x_reg  [NUM_EDGE];
    prod_t dprod_y_reg  [NUM_EDGE];

    // Stage 2: dot products
    dot_t pdot_next [NUM_PAIR];
    dot_t ddot_next [NUM_EDGE];
    dot_t pdot_reg  [NUM_PAIR];
    dot_t ddot_reg  [NUM_EDGE];

    // Stage 3: magnitudes
    mag_t pmag_next [NUM_PAIR];
    mag_t dmag_next [NUM_EDGE];
    mag_t pmag_reg  [NUM_PAIR];
    mag_t dmag_reg  [NUM_EDGE];

    // Stage 4: partial spans and doubled distance per axis
    sum_t half_a_next [NUM_EDGE];
    sum_t half_b_next [NUM_EDGE];
    sum_t dist_next   [NUM_EDGE];
    sum_t half_a_reg  [NUM_EDGE];
    sum_t half_b_reg  [NUM_EDGE];
    sum_t dist_reg    [NUM_EDGE];

    // Stage 5: full span per axis
    sum_t span_next  [NUM_EDGE];
    sum_t span_reg   [NUM_EDGE];
    sum_t dist2_reg  [NUM_EDGE];

    // Stage 6: result
    logic overlap_next;
    logic overlap_reg;

    // Ready chain: a stage takes new data when empty or when it drains
    always_comb
    begin
        stage_ready[LAST] = !stage_valid_reg[LAST] || !out_stall;
        for (int s = LAST - 1; s >= 0; s--)
        begin
            stage_ready[s] = !stage_valid_reg[s] || stage_ready[s+1];
        end
        stage_valid_next = stage_valid_reg;
        if (stage_ready[0])
        begin
            stage_valid_next[0] = in_valid;
        end
        for (int s = 1; s < NUM_STAGE; s++)
        begin
            if (stage_ready[s])
            begin
                stage_valid_next[s] = stage_valid_reg[s-1];
            end
        end
        stage_load[0] = stage_ready[0] && in_valid;
        for (int s = 1; s < NUM_STAGE; s++)
        begin
            stage_load[s] = stage_ready[s] && stage_valid_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage 0: capture edges, form center difference
    always_ff @(posedge clk)
    begin
        if (stage_load[0])
        begin
            dx_reg    <= diff_t'(left_center_x) - diff_t'(right_center_x);
            dy_reg    <= diff_t'(left_center_y) - diff_t'(right_center_y);
            ex_reg[0] <= left_edge_u_x;
            ey_reg[0] <= left_edge_u_y;
            ex_reg[1] <= left_edge_v_x;
            ey_reg[1] <= left_edge_v_y;
            ex_reg[2] <= right_edge_u_x;
            ey_reg[2] <= right_edge_u_y;
            ex_reg[3] <= right_edge_v_x;
            ey_reg[3] <= right_edge_v_y;
        end
    end

    // Stage 1: multiply edge pairs and center difference by each edge
    always_comb
    begin
        for (int p = 0; p < NUM_PAIR; p++)
        begin
            pprod_x_next[p] = diff_t'(ex_reg[PAIR_A[p]]) * diff_t'(ex_reg[PAIR_B[p]]);
            pprod_y_next[p] = diff_t'(ey_reg[PAIR_A[p]]) * diff_t'(ey_reg[PAIR_B[p]]);
        end
        for (int i = 0; i < NUM_EDGE; i++)
        begin
            dprod_x_next[i] = dx_reg * diff_t'(ex_reg[i]);
            dprod_y_next[i] = dy_reg * diff_t'(ey_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[1])
        begin
            pprod_x_reg <= pprod_x_next;
            pprod_y_reg <= pprod_y_next;
            dprod_x_reg <= dprod_x_next;
            dprod_y_reg <= dprod_y_next;
        end
    end

    // Stage 2: sum x and y products into dot products
    always_comb
    begin
        for (int p = 0; p < NUM_PAIR; p++)
        begin
            pdot_next[p] = dot_t'(pprod_x_reg[p]) + dot_t'(pprod_y_reg[p]);
        end
        for (int i = 0; i < NUM_EDGE; i++)
        begin
            ddot_next[i] = dot_t'(dprod_x_reg[i]) + dot_t'(dprod_y_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[2])
        begin
            pdot_reg <= pdot_next;
            ddot_reg <= ddot_next;
        end
    end

    // Stage 3: take magnitudes
    always_comb
    begin
        for (int p = 0; p < NUM_PAIR; p++)
        begin
            pmag_next[p] = mag_t'(pdot_reg[p][DOT_W-1] ? -pdot_reg[p] : pdot_reg[p]);
        end
        for (int i = 0; i < NUM_EDGE; i++)
        begin
            dmag_next[i] = mag_t'(ddot_reg[i][DOT_W-1] ? -ddot_reg[i] : ddot_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[3])
        begin
            pmag_reg <= pmag_next;
            dmag_reg <= dmag_next;
        end
    end

    // Stage 4: gather the four projections of each axis in two halves
    always_comb
    begin
        for (int i = 0; i < NUM_EDGE; i++)
        begin
            half_a_next[i] = sum_t'(pmag_reg[PAIR_IDX[i][0]])
                           + sum_t'(pmag_reg[PAIR_IDX[i][1]]);
            half_b_next[i] = sum_t'(pmag_reg[PAIR_IDX[i][2]])
                           + sum_t'(pmag_reg[PAIR_IDX[i][3]]);
            dist_next[i]   = sum_t'({dmag_reg[i], 1'b0});
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[4])
        begin
            half_a_reg <= half_a_next;
            half_b_reg <= half_b_next;
            dist_reg   <= dist_next;
        end
    end

    // Stage 5: finish the span of each axis
    always_comb
    begin
        for (int i = 0; i < NUM_EDGE; i++)
        begin
            span_next[i] = half_a_reg[i] + half_b_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[5])
        begin
            span_reg  <= span_next;
            dist2_reg <= dist_reg;
        end
    end

    // Stage 6: any axis with span below distance separates the boxes
    always_comb
    begin
        overlap_next = 1'b1;
        for (int i = 0; i < NUM_EDGE; i++)
        begin
            if (span_reg[i] < dist2_reg[i])
            begin
                overlap_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load[6])
        begin
            overlap_reg <= overlap_next;
        end
    end

    assign in_stall  = !stage_ready[0];
    assign out_valid = stage_valid_reg[LAST];
    assign overlap   = overlap_reg;

`ifndef SYNTHESIS
    // An accepted transaction lands in the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> stage_valid_reg[0])
        else $error("accepted transaction did not enter stage 0");

    // Input stalls only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&stage_valid_reg) && out_stall))
        else $error("input stalled while the pipeline had room");

    // Stage 5 keeps its item while the full last stage is held by out_stall
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg[LAST-1] && !stage_ready[LAST]) |=> stage_valid_reg[LAST-1])
        else $error("item dropped from stage 5 under stall");
`endif

endmodule
